// ----- hdl/tick_bar_rsi_atr_tracker_macros.svh -----
// Assertion helpers shared by the RTL; both sample on clk and are off during rst.
`ifndef TICK_BAR_RSI_ATR_TRACKER_MACROS_SVH
`define TICK_BAR_RSI_ATR_TRACKER_MACROS_SVH

// Same-cycle implication.
`define TBRAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TBRAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tbrat_pkg.sv -----
package tbrat_pkg;

  // Field widths
  localparam int PRICE_W    = 24;
  localparam int MID_W      = 25;
  localparam int TIME_W     = 47;
  localparam int LEN_W      = 22;
  localparam int RSI_W      = 14;
  localparam int ATR_OUT_W  = 33;
  localparam int ATR_FRAC   = 8;

  // Default window lengths
  localparam int RSI_WINDOW_DEF = 14;
  localparam int ATR_WINDOW_DEF = 14;

  // Register and RSI constants
  localparam logic [LEN_W-1:0] LEN_RESET = 22'd60000;
  localparam logic [RSI_W-1:0] RSI_FULL  = 14'd10000;
  localparam logic [RSI_W-1:0] RSI_MID   = 14'd5000;

  typedef struct packed {
    logic [PRICE_W-1:0] bid_price;
    logic [PRICE_W-1:0] ask_price;
    logic [TIME_W-1:0]  time_ms;
  } tick_t;

  typedef struct packed {
    logic                 new_bar;
    logic [MID_W-1:0]     bar_open;
    logic [MID_W-1:0]     bar_high;
    logic [MID_W-1:0]     bar_low;
    logic [MID_W-1:0]     bar_last;
    logic [RSI_W-1:0]     rsi_centi;
    logic                 rsi_ready;
    logic [ATR_OUT_W-1:0] atr_q8;
    logic                 atr_ready;
  } result_t;

  // Divider operand select
  typedef enum logic [1:0] {
    DIV_BUCKET = 2'd0,
    DIV_RSI    = 2'd1,
    DIV_ATR    = 2'd2
  } div_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     bucket_take;
    logic     push;
    logic     rsi_mul;
    logic     rsi_max;
    logic     rsi_take;
    logic     bar_step;
    logic     atr_upd;
    logic     atr_take;
    logic     emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic rsi_full;
    logic loss_zero;
    logic atr_close;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/tbrat_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tbrat_div #(
  parameter int DVD_W = 47,
  parameter int DVS_W = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One trial subtraction
  always_comb begin
    rem_sh = {rem, quo[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      if (cnt == CNT_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- hdl/tbrat_ctrl.sv -----
// Sequencer: one item at a time through bucket, RSI, bar and ATR steps.
module tbrat_ctrl import tbrat_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick_valid,
  output logic       tick_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_BKT_GO   = 12'b0000_0000_0010,
    ST_BKT_WAIT = 12'b0000_0000_0100,
    ST_CHG      = 12'b0000_0000_1000,
    ST_RSI_CHK  = 12'b0000_0001_0000,
    ST_RSI_GO   = 12'b0000_0010_0000,
    ST_RSI_WAIT = 12'b0000_0100_0000,
    ST_BAR      = 12'b0000_1000_0000,
    ST_ATR_UPD  = 12'b0001_0000_0000,
    ST_ATR_GO   = 12'b0010_0000_0000,
    ST_ATR_WAIT = 12'b0100_0000_0000,
    ST_EMIT     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_BUCKET;
    state_next = state;
    tick_stall = rst || (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (tick_valid && !tick_stall) begin
          cmd.load   = 1'b1;
          state_next = ST_BKT_GO;
        end
      end
      ST_BKT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_BUCKET;
        state_next    = ST_BKT_WAIT;
      end
      ST_BKT_WAIT: begin
        if (st.div_done) begin
          cmd.bucket_take = 1'b1;
          state_next      = ST_CHG;
        end
      end
      ST_CHG: begin
        cmd.push   = 1'b1;
        state_next = ST_RSI_CHK;
      end
      ST_RSI_CHK: begin
        cmd.rsi_mul = 1'b1;
        if (!st.rsi_full) begin
          state_next = ST_BAR;
        end else if (st.loss_zero) begin
          cmd.rsi_max = 1'b1;
          state_next  = ST_BAR;
        end else begin
          state_next = ST_RSI_GO;
        end
      end
      ST_RSI_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RSI;
        state_next    = ST_RSI_WAIT;
      end
      ST_RSI_WAIT: begin
        if (st.div_done) begin
          cmd.rsi_take = 1'b1;
          state_next   = ST_BAR;
        end
      end
      ST_BAR: begin
        cmd.bar_step = 1'b1;
        state_next   = st.atr_close ? ST_ATR_UPD : ST_EMIT;
      end
      ST_ATR_UPD: begin
        cmd.atr_upd = 1'b1;
        state_next  = ST_ATR_GO;
      end
      ST_ATR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ATR;
        state_next    = ST_ATR_WAIT;
      end
      ST_ATR_WAIT: begin
        if (st.div_done) begin
          cmd.atr_take = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/tbrat_dp.sv -----
// Datapath: tracker state, window rings, shared divider, result register.
module tbrat_dp import tbrat_pkg::*; #(
  parameter int RSI_WINDOW = RSI_WINDOW_DEF,
  parameter int ATR_WINDOW = ATR_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  tick_t            tick,
  input  dp_cmd_t          cmd,
  output dp_status_t       st,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  localparam int RSI_SUM_W  = MID_W + $clog2(RSI_WINDOW + 1);
  localparam int ATR_SUM_W  = MID_W + $clog2(ATR_WINDOW + 1);
  localparam int RSI_PROD_W = RSI_SUM_W + RSI_W;
  localparam int ATR_DVD_W  = ATR_SUM_W + ATR_FRAC;
  localparam int DVD_A      = (TIME_W > RSI_PROD_W) ? TIME_W : RSI_PROD_W;
  localparam int DVD_W      = (DVD_A > ATR_DVD_W) ? DVD_A : ATR_DVD_W;
  localparam int DVS_W      = (LEN_W > RSI_SUM_W) ? LEN_W : RSI_SUM_W;
  localparam int CHG_W      = MID_W + 1;
  localparam int RPTR_W     = $clog2(RSI_WINDOW);
  localparam int RCNT_W     = $clog2(RSI_WINDOW + 1);
  localparam int APTR_W     = $clog2(ATR_WINDOW);
  localparam int ACNT_W     = $clog2(ATR_WINDOW + 2);

  // Config register
  logic [LEN_W-1:0] bar_len;
  logic [LEN_W-1:0] len_eff;

  // Current item
  logic [MID_W-1:0]  mid;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] bucket;

  // RSI state
  logic                    prev_valid;
  logic [MID_W-1:0]        prev_mid;
  logic signed [CHG_W-1:0] change_ring [RSI_WINDOW];
  logic [RCNT_W-1:0]       change_count;
  logic [RPTR_W-1:0]       change_ptr;
  logic [RSI_SUM_W-1:0]    gain_sum, loss_sum;
  logic [RSI_PROD_W-1:0]   rsi_prod;
  logic [RSI_W-1:0]        rsi_value;

  // Bar state
  logic              open_flag;
  logic [TIME_W-1:0] bar_index;
  logic [MID_W-1:0]  cur_open, cur_high, cur_low, cur_close;
  logic [MID_W-1:0]  prev_close;
  logic              hold_nb;
  logic [MID_W-1:0]  hold_open, hold_high, hold_low, hold_close;

  // ATR state
  logic [ACNT_W-1:0]    closed_bars;
  logic [MID_W-1:0]     range_ring [ATR_WINDOW];
  logic [APTR_W-1:0]    range_ptr;
  logic [ATR_SUM_W-1:0] range_sum;
  logic [ATR_OUT_W-1:0] atr_value;
  logic [MID_W-1:0]     tr;

  // Divider
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DVD_W-1:0] div_q;
  logic             div_done;

  // Combinational helpers
  logic signed [CHG_W-1:0] chg, old_chg;
  logic                    chg_pos, old_pos;
  logic [CHG_W-1:0]        chg_abs, old_abs;
  logic [RSI_SUM_W-1:0]    gain_next, loss_next, rsi_tot;
  logic                    rsi_full;
  logic                    bar_chg;
  logic [MID_W-1:0]        tr_hl, tr_hc, tr_lc, tr_comb;
  logic                    atr_full;
  logic [ACNT_W-1:0]       atr_n;

  assign len_eff = (bar_len == '0) ? LEN_W'(1) : bar_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_len <= LEN_RESET;
    end else if (cfg_we) begin
      bar_len <= cfg_wdata;
    end
  end

  // Latch item and bucket
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mid    <= MID_W'({1'b0, tick.bid_price} + {1'b0, tick.ask_price});
      time_r <= tick.time_ms;
    end
    if (cmd.bucket_take) begin
      bucket <= div_q[TIME_W-1:0];
    end
  end

  // Change window arithmetic
  always_comb begin
    chg      = $signed({1'b0, mid}) - $signed({1'b0, prev_mid});
    chg_pos  = !chg[CHG_W-1] && (chg != '0);
    chg_abs  = chg[CHG_W-1] ? CHG_W'(-chg) : CHG_W'(chg);
    old_chg  = change_ring[change_ptr];
    old_pos  = !old_chg[CHG_W-1] && (old_chg != '0);
    old_abs  = old_chg[CHG_W-1] ? CHG_W'(-old_chg) : CHG_W'(old_chg);
    rsi_full = (change_count == RCNT_W'(RSI_WINDOW));
    gain_next = gain_sum;
    loss_next = loss_sum;
    if (rsi_full) begin
      if (old_pos) begin
        gain_next = gain_next - RSI_SUM_W'(old_abs);
      end else begin
        loss_next = loss_next - RSI_SUM_W'(old_abs);
      end
    end
    if (chg_pos) begin
      gain_next = gain_next + RSI_SUM_W'(chg_abs);
    end else begin
      loss_next = loss_next + RSI_SUM_W'(chg_abs);
    end
    rsi_tot = gain_sum + loss_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.push && prev_valid) begin
      change_ring[change_ptr] <= chg;
    end
  end

  // RSI state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid   <= 1'b0;
      prev_mid     <= '0;
      change_count <= '0;
      change_ptr   <= '0;
      gain_sum     <= '0;
      loss_sum     <= '0;
      rsi_value    <= RSI_MID;
    end else begin
      if (cmd.push) begin
        prev_mid   <= mid;
        prev_valid <= 1'b1;
        if (prev_valid) begin
          gain_sum <= gain_next;
          loss_sum <= loss_next;
          if (!rsi_full) begin
            change_count <= change_count + 1'b1;
          end
          change_ptr <= (change_ptr == RPTR_W'(RSI_WINDOW - 1)) ? '0 : change_ptr + 1'b1;
        end
      end
      if (cmd.rsi_max) begin
        rsi_value <= RSI_FULL;
      end else if (cmd.rsi_take) begin
        rsi_value <= div_q[RSI_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsi_mul) begin
      rsi_prod <= RSI_PROD_W'(gain_sum) * RSI_PROD_W'(RSI_FULL);
    end
  end

  // True range against the previous close
  always_comb begin
    bar_chg = !open_flag || (bucket != bar_index);
    tr_hl   = cur_high - cur_low;
    tr_hc   = (cur_high >= prev_close) ? cur_high - prev_close
                                       : prev_close - cur_high;
    tr_lc   = (cur_low >= prev_close) ? cur_low - prev_close
                                      : prev_close - cur_low;
    tr_comb = tr_hl;
    if (tr_hc > tr_comb) tr_comb = tr_hc;
    if (tr_lc > tr_comb) tr_comb = tr_lc;
    atr_full = (closed_bars == ACNT_W'(ATR_WINDOW + 1));
    atr_n    = closed_bars - ACNT_W'(1);
  end

  // Bar building and ATR window
  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag      <= 1'b0;
      bar_index      <= '0;
      cur_open       <= '0;
      cur_high       <= '0;
      cur_low        <= '0;
      cur_close      <= '0;
      prev_close     <= '0;
      closed_bars    <= '0;
      range_ptr      <= '0;
      range_sum      <= '0;
      atr_value      <= '0;
      hold_nb        <= 1'b0;
    end else begin
      if (cmd.bar_step) begin
        tr <= tr_comb;
        if (bar_chg) begin
          hold_nb    <= open_flag;
          hold_open  <= open_flag ? cur_open : '0;
          hold_high  <= open_flag ? cur_high : '0;
          hold_low   <= open_flag ? cur_low : '0;
          hold_close <= open_flag ? cur_close : '0;
          if (open_flag) begin
            prev_close <= cur_close;
            if (closed_bars == '0) begin
              closed_bars <= ACNT_W'(1);
            end
          end
          cur_open  <= mid;
          cur_high  <= mid;
          cur_low   <= mid;
          cur_close <= mid;
          bar_index <= bucket;
          open_flag <= 1'b1;
        end else begin
          hold_nb    <= 1'b0;
          hold_open  <= '0;
          hold_high  <= '0;
          hold_low   <= '0;
          hold_close <= '0;
          if (mid > cur_high) cur_high <= mid;
          if (mid < cur_low) cur_low <= mid;
          cur_close <= mid;
        end
      end
      if (cmd.atr_upd) begin
        range_sum <= range_sum - (atr_full ? ATR_SUM_W'(range_ring[range_ptr]) : '0)
                     + ATR_SUM_W'(tr);
        range_ptr <= (range_ptr == APTR_W'(ATR_WINDOW - 1)) ? '0 : range_ptr + 1'b1;
        if (!atr_full) begin
          closed_bars <= closed_bars + 1'b1;
        end
      end
      if (cmd.atr_take) begin
        atr_value <= div_q[ATR_OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.atr_upd) begin
      range_ring[range_ptr] <= tr;
    end
  end

  // Divider operands
  always_comb begin
    case (cmd.div_sel)
      DIV_BUCKET: begin
        div_dvd = DVD_W'(time_r);
        div_dvs = DVS_W'(len_eff);
      end
      DIV_RSI: begin
        div_dvd = DVD_W'(rsi_prod);
        div_dvs = DVS_W'(rsi_tot);
      end
      DIV_ATR: begin
        div_dvd = DVD_W'({range_sum, {ATR_FRAC{1'b0}}});
        div_dvs = DVS_W'(atr_n);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  tbrat_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .done     (div_done)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.new_bar   <= hold_nb;
      result.bar_open  <= hold_open;
      result.bar_high  <= hold_high;
      result.bar_low   <= hold_low;
      result.bar_last  <= hold_close;
      result.rsi_centi <= rsi_value;
      result.rsi_ready <= rsi_full;
      result.atr_q8    <= atr_value;
      result.atr_ready <= (closed_bars >= ACNT_W'(2));
    end
  end

  // Status
  always_comb begin
    st.div_done  = div_done;
    st.rsi_full  = rsi_full;
    st.loss_zero = (loss_sum == '0);
    st.atr_close = open_flag && (bucket != bar_index) && (closed_bars != '0);
    st.out_free  = !result_valid || !result_stall;
  end

endmodule

// ----- hdl/tick_bar_rsi_atr_tracker.sv -----
// Every item takes a bar bucket division; an RSI division follows when the change window
// is full and the loss sum is nonzero, an ATR division when a bar other than the first
// closes. All run on the one shared restoring divider. Items are taken one at a time: the
// next is accepted only after the result is emitted, which waits while the result is stalled.
// Reset (rst, synchronous, active high): empty windows, no open bar, RSI 5000,
// ATR 0, bar length 60000 ms; no result pending; input stalled while in reset.
`include "tick_bar_rsi_atr_tracker_macros.svh"

module tick_bar_rsi_atr_tracker import tbrat_pkg::*; #(
  parameter int RSI_WINDOW = RSI_WINDOW_DEF,
  parameter int ATR_WINDOW = ATR_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             tick_valid,
  output logic             tick_stall,
  input  tick_t            tick,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       res_bar;
  logic       bar_ok;
  logic       bar_clear;

  tbrat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .st         (st),
    .cmd        (cmd)
  );

  tbrat_dp #(
    .RSI_WINDOW(RSI_WINDOW),
    .ATR_WINDOW(ATR_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .tick         (tick),
    .cmd          (cmd),
    .st           (st),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Checks
  assign res_bar   = result_valid && result.new_bar;
  assign bar_ok    = (result.bar_low <= result.bar_high) && (result.bar_low <= result.bar_open);
  assign bar_clear = (result.bar_open == '0) && (result.bar_last == '0);

  `TBRAT_ASSERT_NEXT(a_accept_busy, tick_valid && !tick_stall, tick_stall, "item while busy")
  `TBRAT_ASSERT_NEXT(a_div_clear, cmd.div_start, !st.div_done, "divider done not cleared")
  `TBRAT_ASSERT_IMPL(a_rsi_range, result_valid, result.rsi_centi <= RSI_FULL, "RSI out of range")
  `TBRAT_ASSERT_IMPL(a_bar_order, res_bar, bar_ok, "bar low above high or open")
  `TBRAT_ASSERT_IMPL(a_no_bar_zero, result_valid && !result.new_bar, bar_clear, "bar set, no bar")

endmodule
